// File: rtl/core/tcw_pkg.sv
// Shared types and constants for the Tahoe congestion window controller.
package tcw_pkg;

   localparam int unsigned SEQ_WIDTH = 16;
   localparam int unsigned WIN_COUNT_WIDTH = SEQ_WIDTH + 1;
   localparam int unsigned CSR_INDEX_WIDTH = 4;

   localparam logic [SEQ_WIDTH-1:0] CWND_MAX = '1;
   localparam logic [SEQ_WIDTH-1:0] PACKET_COUNT_RESET = 16'd30;
   localparam logic [SEQ_WIDTH-1:0] SSTHRESH_RESET = 16'd4;
   localparam logic [1:0] DUP_LIMIT = 2'd3;

   localparam logic OP_SKIP = 1'b0;
   localparam logic OP_SEND = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PACKET_COUNT = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_SSTHRESH = 4'd1;

   typedef struct packed {
      logic                 operation;
      logic [SEQ_WIDTH-1:0] ack_seq;
   } req_payload_type;

   typedef struct packed {
      logic                 sent;
      logic [SEQ_WIDTH-1:0] sent_seq;
      logic                 retransmit;
      logic [SEQ_WIDTH-1:0] retransmit_seq;
      logic [SEQ_WIDTH-1:0] window_size;
      logic [SEQ_WIDTH-1:0] threshold_now;
      logic [1:0]           duplicates;
      logic                 window_done;
      logic                 done_res;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [SEQ_WIDTH-1:0]       data;
   } csr_payload_type;

endpackage

// File: rtl/core/tcw_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
interface tcw_req_if import tcw_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tcw_csr_if import tcw_pkg::*; ();
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/tahoe_congestion_window.sv
// Top level of the Tahoe-style congestion window controller.
//
// One request gives exactly one result, in the cycle after its transfer. The
// whole window update is a single combinational pass between the state
// registers and the result register, so a request can be taken in every
// cycle: req_bus.ready is high whenever the result register is empty or its
// result is being taken in the same cycle. Register writes are always
// accepted; writing packet_count reloads the remaining packet budget and
// writing initial_ssthresh reloads the slow start threshold.
module tahoe_congestion_window
   import tcw_pkg::*;
(
   input logic        clock,
   input logic        reset,
   tcw_req_if.sink    req_bus,
   tcw_rsp_if.source  rsp_bus,
   tcw_csr_if.sink    csr_bus
);

   logic [SEQ_WIDTH-1:0]       cwnd_ff, cwnd_in;
   logic [SEQ_WIDTH-1:0]       ssthresh_ff, ssthresh_in;
   logic [1:0]                 dup_count_ff, dup_count_in;
   logic [WIN_COUNT_WIDTH-1:0] sent_in_window_ff, sent_in_window_in;
   logic [SEQ_WIDTH-1:0]       last_ack_ff, last_ack_in;
   logic                       recovery_armed_ff, recovery_armed_in;
   logic [SEQ_WIDTH-1:0]       remaining_ff, remaining_in;
   logic                       finished_ff, finished_in;
   logic                       rsp_valid_ff;
   rsp_payload_type            rsp_payload_ff, rsp_payload_in;

   logic req_transfer;
   logic csr_write;
   logic send_ok;
   logic used;
   logic [WIN_COUNT_WIDTH-1:0] window_less_one;
   logic [SEQ_WIDTH:0]         cwnd_doubled;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_transfer  = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid;

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

   assign cwnd_doubled = {cwnd_ff, 1'b0};

   always_comb begin
      cwnd_in           = cwnd_ff;
      ssthresh_in       = ssthresh_ff;
      dup_count_in      = dup_count_ff;
      sent_in_window_in = sent_in_window_ff;
      last_ack_in       = last_ack_ff;
      recovery_armed_in = recovery_armed_ff;
      remaining_in      = remaining_ff;
      finished_in       = finished_ff;
      rsp_payload_in    = '0;
      send_ok           = 1'b0;
      used              = 1'b0;
      window_less_one   = '0;

      if (!finished_ff) begin
         if (remaining_ff == '0) begin
            finished_in = 1'b1;
         end else begin
            send_ok = (req_bus.payload.operation == OP_SEND) &&
                      (dup_count_ff != DUP_LIMIT) && recovery_armed_ff;
            if (send_ok) begin
               rsp_payload_in.sent     = 1'b1;
               rsp_payload_in.sent_seq = remaining_ff - 1'b1;
               sent_in_window_in       = sent_in_window_ff + 1'b1;
               if (req_bus.payload.ack_seq == last_ack_ff) begin
                  dup_count_in = dup_count_ff + 1'b1;
               end else begin
                  dup_count_in = '0;
               end
               last_ack_in = req_bus.payload.ack_seq;
               used        = 1'b1;
            end else if (req_bus.payload.operation == OP_SKIP) begin
               used = 1'b1;
            end
            if (used) begin
               remaining_in = remaining_ff - 1'b1;
            end

            // Recovery is disarmed on the item that sees the third duplicate,
            // so the retransmit falls on the item after it.
            if (dup_count_in == DUP_LIMIT && !recovery_armed_ff) begin
               ssthresh_in                   = cwnd_ff >> 1;
               cwnd_in                       = SEQ_WIDTH'(1);
               dup_count_in                  = '0;
               sent_in_window_in             = WIN_COUNT_WIDTH'(1);
               rsp_payload_in.retransmit     = 1'b1;
               rsp_payload_in.retransmit_seq =
                  (last_ack_in != '0) ? last_ack_in - 1'b1 : '0;
               recovery_armed_in             = 1'b1;
            end else begin
               window_less_one = sent_in_window_in - 1'b1;
               if (window_less_one == {1'b0, cwnd_ff}) begin
                  rsp_payload_in.window_done = 1'b1;
                  sent_in_window_in          = WIN_COUNT_WIDTH'(1);
                  if (cwnd_ff >= ssthresh_ff) begin
                     if (cwnd_ff != CWND_MAX) begin
                        cwnd_in = cwnd_ff + 1'b1;
                     end
                  end else if (cwnd_doubled[SEQ_WIDTH]) begin
                     cwnd_in = CWND_MAX;
                  end else begin
                     cwnd_in = cwnd_doubled[SEQ_WIDTH-1:0];
                  end
               end
               recovery_armed_in = (dup_count_in != DUP_LIMIT);
            end
            if (remaining_in == '0) begin
               finished_in = 1'b1;
            end
         end
      end

      rsp_payload_in.window_size   = cwnd_in;
      rsp_payload_in.threshold_now = ssthresh_in;
      rsp_payload_in.duplicates    = dup_count_in;
      rsp_payload_in.done_res      = finished_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cwnd_ff           <= SEQ_WIDTH'(1);
         ssthresh_ff       <= SSTHRESH_RESET;
         dup_count_ff      <= '0;
         sent_in_window_ff <= WIN_COUNT_WIDTH'(1);
         last_ack_ff       <= '0;
         recovery_armed_ff <= 1'b1;
         remaining_ff      <= PACKET_COUNT_RESET;
         finished_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (req_transfer) begin
            cwnd_ff           <= cwnd_in;
            ssthresh_ff       <= ssthresh_in;
            dup_count_ff      <= dup_count_in;
            sent_in_window_ff <= sent_in_window_in;
            last_ack_ff       <= last_ack_in;
            recovery_armed_ff <= recovery_armed_in;
            remaining_ff      <= remaining_in;
            finished_ff       <= finished_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // The user must write only while idle; the block does not enforce it, and writes take priority all the same.
         if (csr_write) begin
            case (csr_bus.payload.index)
               CSR_PACKET_COUNT: begin
                  remaining_ff <= csr_bus.payload.data;
               end
               CSR_INITIAL_SSTHRESH: begin
                  ssthresh_ff <= csr_bus.payload.data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

// File: test/tb.sv
// Self-checking bench for the Tahoe congestion window controller: directed, random and long-window traffic.
module tb;
   import tcw_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   // Tracks the controller's window state and holds the reports it should produce, oldest first.
   class tahoe_tracker;
      logic [SEQ_WIDTH-1:0]       packet_count;
      logic [SEQ_WIDTH-1:0]       initial_ssthresh;
      logic [SEQ_WIDTH-1:0]       cwnd;
      logic [SEQ_WIDTH-1:0]       ssthresh;
      logic [1:0]                 dup_acks;
      logic [WIN_COUNT_WIDTH-1:0] window_sent;
      logic [SEQ_WIDTH-1:0]       last_ack;
      logic                       recovery_armed;
      logic [SEQ_WIDTH-1:0]       packets_left;
      logic                       finished;
      rsp_payload_type            pending_reports[$];
      int requests, checked, sends, blocked, retransmits, growths;
      int doubling_clamps, held_at_max, ignored, failures, reported;

      function new();
         packet_count = PACKET_COUNT_RESET;
         initial_ssthresh = SSTHRESH_RESET;
         cwnd = 16'd1;
         ssthresh = SSTHRESH_RESET;
         dup_acks = '0;
         window_sent = 17'd1;
         last_ack = '0;
         recovery_armed = 1'b1;
         packets_left = PACKET_COUNT_RESET;
         finished = 1'b0;
      endfunction

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                   logic [SEQ_WIDTH-1:0] data);
         case (index)
            CSR_PACKET_COUNT: begin
               packet_count = data;
               packets_left = data;
            end
            CSR_INITIAL_SSTHRESH: begin
               initial_ssthresh = data;
               ssthresh = data;
            end
            default: ;
         endcase
      endfunction

      function void note_request(req_payload_type req);
         rsp_payload_type report;
         logic            consumed;
         int unsigned     doubled;
         report = '0;
         consumed = 1'b0;
         requests++;
         if (finished) begin
            ignored++;
         end else if (packets_left == '0) begin
            finished = 1'b1;
         end else begin
            if (req.operation == OP_SEND && dup_acks != DUP_LIMIT && recovery_armed) begin
               report.sent = 1'b1;
               report.sent_seq = packets_left - 16'd1;
               window_sent = window_sent + 17'd1;
               consumed = 1'b1;
               if (req.ack_seq == last_ack) dup_acks = dup_acks + 2'd1;
               else dup_acks = '0;
               last_ack = req.ack_seq;
               sends++;
            end else if (req.operation == OP_SKIP) begin
               consumed = 1'b1;
            end else begin
               blocked++;
            end
            if (consumed) packets_left = packets_left - 16'd1;

            if (dup_acks == DUP_LIMIT && !recovery_armed) begin
               ssthresh = cwnd >> 1;
               cwnd = 16'd1;
               dup_acks = '0;
               window_sent = 17'd1;
               report.retransmit = 1'b1;
               report.retransmit_seq = (last_ack != '0) ? last_ack - 16'd1 : '0;
               recovery_armed = 1'b1;
               retransmits++;
            end else begin
               if (window_sent == {1'b0, cwnd} + 17'd1) begin
                  report.window_done = 1'b1;
                  window_sent = 17'd1;
                  growths++;
                  if (cwnd >= ssthresh) begin
                     if (cwnd < CWND_MAX) cwnd = cwnd + 16'd1;
                     else held_at_max++;
                  end else begin
                     doubled = 2 * int'(cwnd);
                     if (doubled > CWND_MAX) begin
                        cwnd = CWND_MAX;
                        doubling_clamps++;
                     end else begin
                        cwnd = doubled[SEQ_WIDTH-1:0];
                     end
                  end
               end
               recovery_armed = (dup_acks != DUP_LIMIT);
            end
            if (packets_left == '0) finished = 1'b1;
         end
         report.window_size = cwnd;
         report.threshold_now = ssthresh;
         report.duplicates = dup_acks;
         report.done_res = finished;
         pending_reports.push_back(report);
      endfunction

      function void check_report(rsp_payload_type got);
         rsp_payload_type want;
         string           diff;
         diff = "";
         if (pending_reports.size() == 0) begin
            failures++;
            if (reported < 10)
               $display("Result transfer with no request outstanding: %p", got);
            reported++;
            return;
         end
         want = pending_reports.pop_front();
         checked++;
         if (got.sent !== want.sent)
            diff = {diff, $sformatf(" sent %0d/%0d", want.sent, got.sent)};
         if (got.sent_seq !== want.sent_seq)
            diff = {diff, $sformatf(" sent_seq %0d/%0d", want.sent_seq, got.sent_seq)};
         if (got.retransmit !== want.retransmit)
            diff = {diff, $sformatf(" retransmit %0d/%0d", want.retransmit, got.retransmit)};
         if (got.retransmit_seq !== want.retransmit_seq)
            diff = {diff, $sformatf(" retransmit_seq %0d/%0d",
                                    want.retransmit_seq, got.retransmit_seq)};
         if (got.window_size !== want.window_size)
            diff = {diff, $sformatf(" window_size %0d/%0d", want.window_size, got.window_size)};
         if (got.threshold_now !== want.threshold_now)
            diff = {diff, $sformatf(" threshold_now %0d/%0d",
                                    want.threshold_now, got.threshold_now)};
         if (got.duplicates !== want.duplicates)
            diff = {diff, $sformatf(" duplicates %0d/%0d", want.duplicates, got.duplicates)};
         if (got.window_done !== want.window_done)
            diff = {diff, $sformatf(" window_done %0d/%0d", want.window_done, got.window_done)};
         if (got.done_res !== want.done_res)
            diff = {diff, $sformatf(" done_res %0d/%0d", want.done_res, got.done_res)};
         if (diff != "") begin
            failures++;
            if (reported < 10)
               $display("Result %0d differs (expected/actual):%s", checked, diff);
            reported++;
         end
      endfunction

      function int pending_count();
         return pending_reports.size();
      endfunction

      function int failure_total();
         if (pending_reports.size() != 0)
            $display("%0d results never arrived.", pending_reports.size());
         return failures + pending_reports.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();
   tcw_csr_if csr_if ();

   tahoe_congestion_window dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   tahoe_tracker         sb;
   logic                 idling_on;
   logic [SEQ_WIDTH-1:0] last_ack_driven;
   int                   offered;
   int                   cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic offer(input logic op, input logic [SEQ_WIDTH-1:0] ack);
      req_payload_type item;
      item.operation = op;
      item.ack_seq = ack;
      if (idling_on && $urandom_range(0, 99) < 21) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(item);
      offered++;
      if (op == OP_SEND) last_ack_driven = ack;
   endtask

   // Stops offering and waits until every outstanding result has been taken.
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending_count() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [SEQ_WIDTH-1:0] data);
      csr_payload_type word;
      word.index = index;
      word.data = data;
      csr_if.valid <= 1'b1;
      csr_if.payload <= word;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.write_register(index, data);
   endtask

   // A negative value leaves that register alone.
   task automatic set_registers(input int count_value, input int thresh_value);
      if (count_value >= 0) write_csr(CSR_PACKET_COUNT, 16'(count_value));
      if (thresh_value >= 0) write_csr(CSR_INITIAL_SSTHRESH, 16'(thresh_value));
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [SEQ_WIDTH-1:0] fresh_ack();
      logic [SEQ_WIDTH-1:0] ack;
      ack = 16'($urandom_range(0, 65535));
      if (ack == last_ack_driven) ack = ack + 16'd1;
      return ack;
   endfunction

   function automatic logic coin_op();
      return ($urandom_range(0, 1) == 1) ? OP_SEND : OP_SKIP;
   endfunction

   // Result side: checks every transfer, idles at random and holds off twice for a long stretch.
   initial begin
      int unsigned hold_left;
      int unsigned taken;
      hold_left = 0;
      taken = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_report(rsp_if.payload);
            taken++;
            if (taken == 250 || taken == 700) hold_left = 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !(idling_on && $urandom_range(0, 99) < 21);
         end
      end
   end

   initial begin
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("Timed out with %0d results outstanding.", sb.pending_count());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int                   phase;
      int                   thresh;
      int                   budget;
      int                   quota;
      int                   pick;
      int                   fails;
      logic [SEQ_WIDTH-1:0] ack;
      sb = new();
      idling_on = 1'b1;
      last_ack_driven = '0;
      offered = 0;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid <= 1'b0;
      csr_if.payload <= '0;
      rsp_if.ready <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Opening sequence on the reset settings. An ack of zero straight after reset already
      // counts as a duplicate, so three of them block the next send and retransmit at zero.
      offer(OP_SEND, 16'h0000);
      offer(OP_SEND, 16'h0000);
      offer(OP_SEND, 16'h0000);
      offer(OP_SEND, 16'h0005);
      offer(OP_SKIP, 16'h0000);
      // Second duplicate at the top ack value, then a skip; no retransmit follows here.
      offer(OP_SEND, 16'hFFFF);
      offer(OP_SEND, 16'hFFFF);
      offer(OP_SEND, 16'hFFFF);
      offer(OP_SKIP, 16'hFFFF);
      for (int i = 1; i <= 7; i++) offer(OP_SEND, 16'(i));
      offer(OP_SKIP, 16'h0000);
      offer(OP_SEND, 16'h8000);
      offer(OP_SEND, 16'h8000);
      offer(OP_SEND, 16'h1234);
      offer(OP_SEND, 16'h5555);
      offer(OP_SEND, 16'hAAAA);

      for (phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: thresh = 1;
            1: thresh = 65535;
            2: thresh = 0;
            default: thresh = ($urandom_range(0, 1) == 1) ? $urandom_range(2, 40)
                                                          : $urandom_range(0, 65535);
         endcase
         budget = (phase == 0) ? 65535 : $urandom_range(400, 65535);
         set_registers(budget, thresh);
         quota = offered + 120;
         while (offered < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               repeat ($urandom_range(1, 10)) offer(OP_SEND, fresh_ack());
            end else if (pick < 65) begin
               // Three duplicates in a row; whatever follows carries the retransmit.
               ack = fresh_ack();
               offer(OP_SEND, ack);
               repeat (3) offer(OP_SEND, ack);
               offer(coin_op(), 16'($urandom_range(0, 65535)));
            end else if (pick < 75) begin
               ack = fresh_ack();
               offer(OP_SEND, ack);
               repeat ($urandom_range(1, 2)) offer(OP_SEND, ack);
               offer(OP_SEND, fresh_ack());
            end else if (pick < 88) begin
               repeat ($urandom_range(1, 4)) offer(OP_SKIP, 16'($urandom_range(0, 65535)));
            end else begin
               repeat ($urandom_range(1, 4))
                  offer(coin_op(), ($urandom_range(0, 1) == 1) ? last_ack_driven
                                                               : 16'($urandom_range(0, 65535)));
            end
         end
      end

      // Loss-free stretch with no idling and the threshold at the ceiling, so the window keeps
      // growing by whole windows. The budget is reloaded whenever it runs low, so that
      // completion is never reached here.
      offer(OP_SKIP, 16'h0000);
      drain();
      idling_on = 1'b0;
      set_registers(65535, 65535);
      ack = sb.last_ack;
      repeat (150) begin
         if (sb.packets_left < 16'd4) begin
            drain();
            set_registers(65535, -1);
         end
         ack = ack + 16'd1;
         offer(OP_SEND, ack);
      end
      idling_on = 1'b1;

      // Completion, either by using up a budget of one or by finding an empty budget.
      drain();
      set_registers(($urandom_range(0, 1) == 1) ? 0 : 1, -1);
      repeat (8) offer(coin_op(), 16'($urandom_range(0, 65535)));

      drain();
      repeat (4) @(posedge clock);
      fails = sb.failure_total();
      $display("Run covered %0d requests and %0d results: %0d sends, %0d blocked sends, %0d fast retransmits.",
               sb.requests, sb.checked, sb.sends, sb.blocked, sb.retransmits);
      $display("Window grew %0d times (clamped %0d doubling, held %0d at ceiling); %0d after completion, %0d failures.",
               sb.growths, sb.doubling_clamps, sb.held_at_max, sb.ignored, fails);
      if (fails == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tahoe_congestion_window.sv
test/tb.sv
